/* hdl/dsr_pkg.sv */
// ----------------------------------------------------------------------------
// dsr_pkg
// Shared types, constants and tables of the disk rejection sampler.
// ----------------------------------------------------------------------------
package dsr_pkg;

  localparam int FRAC_BITS_DEFAULT    = 28;
  localparam int CORDIC_STEPS_DEFAULT = 24;

  localparam int WORK_FRAC = 30;
  localparam int EXP_TERMS = 12;

  localparam logic [30:0] WORK_ONE   = 31'h4000_0000;
  localparam logic [30:0] EINV_Q30   = 31'd395007542;
  localparam logic [30:0] TENTH_Q30  = 31'd107374182;
  localparam logic [30:0] HALFPI_Q30 = 31'd1686629713;
  localparam logic [63:0] KINF_Q30   = 64'd652032874;
  localparam logic [63:0] KINF_2_3   = 64'd434688582;

  typedef enum logic [2:0] {
    REG_RADIUS_LOW     = 3'd0,
    REG_RADIUS_HIGH    = 3'd1,
    REG_HEIGHT_LOW     = 3'd2,
    REG_HEIGHT_HIGH    = 3'd3,
    REG_PARTICLE_TOTAL = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic load;
    logic scale;
    logic pos;
    logic sq;
    logic wset;
    logic exp_a;
    logic exp_b;
    logic exp_c;
    logic kstep;
    logic tenth;
    logic ang;
    logic cordic;
    logic rot;
    logic mul;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic finished;
    logic exp_last;
    logic k_zero;
    logic cordic_last;
    logic div_done;
    logic accept_ok;
    logic out_free;
  } dp_status_t;

  // floor((2^32-1)/n), used with a one-step correction
  function automatic logic [31:0] recip_q32(input logic [3:0] n);
    logic [31:0] v;
    unique case (n)
      4'd1:    v = 32'd4294967295;
      4'd2:    v = 32'd2147483647;
      4'd3:    v = 32'd1431655765;
      4'd4:    v = 32'd1073741823;
      4'd5:    v = 32'd858993459;
      4'd6:    v = 32'd715827882;
      4'd7:    v = 32'd613566756;
      4'd8:    v = 32'd536870911;
      4'd9:    v = 32'd477218588;
      4'd10:   v = 32'd429496729;
      4'd11:   v = 32'd390451572;
      4'd12:   v = 32'd357913941;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  function automatic logic [30:0] atan_q30(input logic [5:0] i);
    logic [30:0] v;
    unique case (i)
      6'd0:    v = 31'd843314857;
      6'd1:    v = 31'd497837829;
      6'd2:    v = 31'd263043837;
      6'd3:    v = 31'd133525159;
      6'd4:    v = 31'd67021687;
      6'd5:    v = 31'd33543516;
      6'd6:    v = 31'd16775851;
      6'd7:    v = 31'd8388437;
      6'd8:    v = 31'd4194283;
      6'd9:    v = 31'd2097149;
      6'd10:   v = 31'd1048576;
      default: v = (i <= 6'd30) ? (31'd1 << (6'd30 - i)) : 31'd0;
    endcase
    return v;
  endfunction

endpackage

/* hdl/dsr_div.sv */
// ----------------------------------------------------------------------------
// dsr_div
// Restoring divider, one quotient bit per cycle: floor(count*2^32/total).
// ----------------------------------------------------------------------------
module dsr_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic [31:0] quot,
  output logic        done
);

  logic [31:0] rem;
  logic [4:0]  cnt;
  logic        busy;
  logic [32:0] t;
  logic        ge;

  assign t    = {rem, 1'b0};
  assign ge   = t >= {1'b0, divisor};
  assign done = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 5'd1;
      if (cnt == 5'd31) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= dividend;
      quot <= '0;
    end else if (busy) begin
      rem  <= ge ? 32'(t - {1'b0, divisor}) : t[31:0];
      quot <= {quot[30:0], ge};
    end
  end

endmodule

/* hdl/dsr_dp.sv */
// ----------------------------------------------------------------------------
// dsr_dp
// Datapath: config registers, scaling, exp test, angle, CORDIC, output reg.
// ----------------------------------------------------------------------------
module dsr_dp #(
  parameter int FRAC_BITS    = dsr_pkg::FRAC_BITS_DEFAULT,
  parameter int CORDIC_STEPS = dsr_pkg::CORDIC_STEPS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic [95:0]         in_data,
  input  dsr_pkg::dp_cmd_t    cmd,
  output dsr_pkg::dp_status_t st,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [127:0]        out_data,
  output logic                out_last
);

  localparam int SHL = (FRAC_BITS < 30) ? 30 - FRAC_BITS : 0;
  localparam int SHR = (FRAC_BITS >= 30) ? FRAC_BITS - 30 : 0;
  localparam int LSH = 2 + FRAC_BITS;
  localparam int IW  = $clog2(CORDIC_STEPS + 1);
  localparam logic [63:0] X0_EXT = dsr_pkg::KINF_Q30 +
    ((2 * CORDIC_STEPS < 63) ? (dsr_pkg::KINF_2_3 >> (2 * CORDIC_STEPS)) : 64'd0);

  logic signed [31:0] rl, rh, hl, hh;
  logic [31:0] total, count;

  logic [31:0] frac_r, frac_z, draw;
  logic [63:0] prod_r, prod_z, lhs_prod;
  logic        neg_r, neg_z;
  logic signed [31:0] r, z;
  logic        big;
  logic [59:0] sq;
  logic [5:0]  k;
  logic [29:0] f;
  logic [30:0] e;
  logic [3:0]  n;
  logic [60:0] p1;
  logic [30:0] pq;
  logic [62:0] p2;
  logic [30:0] rhs;

  logic [1:0]  quad;
  logic signed [33:0] a, x, y, c, s;
  logic [IW-1:0] i;
  logic signed [65:0] px, py;

  logic [31:0] quot;
  logic        div_done;

  logic signed [32:0] dr, dz;
  logic [32:0] mag_r, mag_z;
  logic signed [33:0] r_sum, z_sum;
  logic [31:0] mz;
  logic [63:0] m_ext;
  logic [35:0] w;
  logic [30:0] q0, qv;
  logic [34:0] qn, rem;
  logic [63:0] lhs;
  logic signed [33:0] dx, dy, angv;
  logic [35:0] xs_w, ys_w;
  logic [31:0] xs, ys;

  dsr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.load),
    .dividend (count),
    .divisor  (total),
    .quot     (quot),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rl    <= 32'sd26843546;
      rh    <= 32'sd268435456;
      hl    <= -32'sd134217728;
      hh    <= 32'sd134217728;
      total <= 32'd1000000;
    end else if (cfg_we) begin
      case (cfg_index)
        dsr_pkg::REG_RADIUS_LOW:     rl    <= cfg_data;
        dsr_pkg::REG_RADIUS_HIGH:    rh    <= cfg_data;
        dsr_pkg::REG_HEIGHT_LOW:     hl    <= cfg_data;
        dsr_pkg::REG_HEIGHT_HIGH:    hh    <= cfg_data;
        dsr_pkg::REG_PARTICLE_TOTAL: total <= cfg_data;
        default: ;
      endcase
    end
  end

  assign dr    = 33'(rh) - 33'(rl);
  assign dz    = 33'(hh) - 33'(hl);
  assign mag_r = dr[32] ? 33'(-dr) : 33'(dr);
  assign mag_z = dz[32] ? 33'(-dz) : 33'(dz);
  assign r_sum = 34'(rl) + (neg_r ? -{2'b00, prod_r[63:32]} : {2'b00, prod_r[63:32]});
  assign z_sum = 34'(hl) + (neg_z ? -{2'b00, prod_z[63:32]} : {2'b00, prod_z[63:32]});
  assign mz    = z[31] ? 32'(-z) : 32'(z);
  assign m_ext = ({32'd0, mz} << SHL) >> SHR;
  assign w     = 36'(sq[59:30]) * 36'd50;
  assign q0    = p2[62:32];
  assign qn    = {4'd0, q0} * {31'd0, n};
  assign rem   = {4'd0, pq} - qn;
  assign qv    = (rem >= 35'(n)) ? q0 + 31'd1 : q0;
  assign lhs   = lhs_prod >> LSH;
  assign angv  = 34'(dsr_pkg::atan_q30(6'(i)));
  assign dx    = y >>> i;
  assign dy    = x >>> i;
  assign xs_w  = px[65:30];
  assign ys_w  = py[65:30];
  assign xs    = (xs_w[35:31] == {5{xs_w[31]}}) ? xs_w[31:0]
               : (xs_w[35] ? 32'h8000_0000 : 32'h7FFF_FFFF);
  assign ys    = (ys_w[35:31] == {5{ys_w[31]}}) ? ys_w[31:0]
               : (ys_w[35] ? 32'h8000_0000 : 32'h7FFF_FFFF);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      frac_r <= in_data[31:0];
      frac_z <= in_data[63:32];
      draw   <= in_data[95:64];
    end
    if (cmd.scale) begin
      prod_r   <= {31'd0, mag_r} * {32'd0, frac_r};
      prod_z   <= {31'd0, mag_z} * {32'd0, frac_z};
      neg_r    <= dr[32];
      neg_z    <= dz[32];
      lhs_prod <= {32'd0, draw} * {33'd0, rh[30:0]};
    end
    if (cmd.pos) begin
      r <= r_sum[31:0];
      z <= z_sum[31:0];
    end
    if (cmd.sq) begin
      big <= |m_ext[63:30];
      sq  <= {30'd0, m_ext[29:0]} * {30'd0, m_ext[29:0]};
    end
    if (cmd.wset) begin
      k <= w[35:30];
      f <= w[29:0];
      e <= dsr_pkg::WORK_ONE;
      n <= 4'(dsr_pkg::EXP_TERMS);
    end
    if (cmd.exp_a) begin
      p1 <= {31'd0, f} * {30'd0, e};
    end
    if (cmd.exp_b) begin
      pq <= p1[60:30];
      p2 <= {32'd0, p1[60:30]} * {31'd0, dsr_pkg::recip_q32(n)};
    end
    if (cmd.exp_c) begin
      e <= dsr_pkg::WORK_ONE - qv;
      n <= n - 4'd1;
    end
    if (cmd.kstep) begin
      e <= 31'(({31'd0, e} * {31'd0, dsr_pkg::EINV_Q30}) >> 30);
      k <= k - 6'd1;
    end
    if (cmd.tenth) begin
      rhs <= big ? 31'd0 : 31'(({31'd0, e} * {31'd0, dsr_pkg::TENTH_Q30}) >> 30);
    end
    if (cmd.ang) begin
      quad <= quot[31:30];
      a    <= 34'(({31'd0, quot[29:0]} * {30'd0, dsr_pkg::HALFPI_Q30}) >> 30);
      x    <= 34'(X0_EXT);
      y    <= '0;
      i    <= '0;
    end
    if (cmd.cordic) begin
      if (!a[33]) begin
        x <= x - dx;
        y <= y + dy;
        a <= a - angv;
      end else begin
        x <= x + dx;
        y <= y - dy;
        a <= a + angv;
      end
      i <= i + IW'(1);
    end
    if (cmd.rot) begin
      unique case (quad)
        2'd0: begin c <= x;  s <= y;  end
        2'd1: begin c <= -y; s <= x;  end
        2'd2: begin c <= -x; s <= -y; end
        2'd3: begin c <= y;  s <= -x; end
      endcase
    end
    if (cmd.mul) begin
      px <= 66'(r) * 66'(c);
      py <= 66'(r) * 66'(s);
    end
    if (cmd.emit) begin
      out_data <= {count, z, ys, xs};
      out_last <= (33'(count) + 33'd1) == {1'b0, total};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        count     <= count + 32'd1;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign st.finished    = count >= total;
  assign st.exp_last    = n == 4'd1;
  assign st.k_zero      = k == 6'd0;
  assign st.cordic_last = i == IW'(CORDIC_STEPS - 1);
  assign st.div_done    = div_done;
  assign st.accept_ok   = rh[31] || (rh == 32'sd0) || (lhs <= {33'd0, rhs});
  assign st.out_free    = !out_valid || out_ready;

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> count == $past(count) + 32'd1)
    else $error("count did not advance on emit");
  a_exp_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.exp_a || cmd.exp_c) |-> n != 4'd0)
    else $error("exp term index out of range");
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("emit overwrote a pending result");
  a_ang_div: assert property (@(posedge clk) disable iff (rst)
    cmd.ang |-> div_done)
    else $error("angle taken before divider finished");

endmodule

/* hdl/dsr_ctrl.sv */
// ----------------------------------------------------------------------------
// dsr_ctrl
// Sequencer of one candidate through the datapath.
// ----------------------------------------------------------------------------
module dsr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  dsr_pkg::dp_status_t st,
  output dsr_pkg::dp_cmd_t    cmd
);

  typedef enum logic [16:0] {
    S_IDLE  = 17'b00000000000000001,
    S_SCALE = 17'b00000000000000010,
    S_POS   = 17'b00000000000000100,
    S_SQ    = 17'b00000000000001000,
    S_WSET  = 17'b00000000000010000,
    S_EXPA  = 17'b00000000000100000,
    S_EXPB  = 17'b00000000001000000,
    S_EXPC  = 17'b00000000010000000,
    S_KMUL  = 17'b00000000100000000,
    S_TENTH = 17'b00000001000000000,
    S_CMP   = 17'b00000010000000000,
    S_DIVW  = 17'b00000100000000000,
    S_ANG   = 17'b00001000000000000,
    S_CORD  = 17'b00010000000000000,
    S_ROT   = 17'b00100000000000000,
    S_MUL   = 17'b01000000000000000,
    S_OUTW  = 17'b10000000000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = state == S_IDLE;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && !st.finished) begin
          cmd.load   = 1'b1;
          state_next = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = S_POS;
      end
      S_POS: begin
        cmd.pos    = 1'b1;
        state_next = S_SQ;
      end
      S_SQ: begin
        cmd.sq     = 1'b1;
        state_next = S_WSET;
      end
      S_WSET: begin
        cmd.wset   = 1'b1;
        state_next = S_EXPA;
      end
      S_EXPA: begin
        cmd.exp_a  = 1'b1;
        state_next = S_EXPB;
      end
      S_EXPB: begin
        cmd.exp_b  = 1'b1;
        state_next = S_EXPC;
      end
      S_EXPC: begin
        cmd.exp_c  = 1'b1;
        state_next = st.exp_last ? S_KMUL : S_EXPA;
      end
      S_KMUL: begin
        if (st.k_zero) begin
          state_next = S_TENTH;
        end else begin
          cmd.kstep = 1'b1;
        end
      end
      S_TENTH: begin
        cmd.tenth  = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        state_next = st.accept_ok ? S_DIVW : S_IDLE;
      end
      S_DIVW: begin
        if (st.div_done) begin
          state_next = S_ANG;
        end
      end
      S_ANG: begin
        cmd.ang    = 1'b1;
        state_next = S_CORD;
      end
      S_CORD: begin
        cmd.cordic = 1'b1;
        if (st.cordic_last) begin
          state_next = S_ROT;
        end
      end
      S_ROT: begin
        cmd.rot    = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_OUTW;
      end
      S_OUTW: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* hdl/disk_rejection_sampler_core.sv */
// ----------------------------------------------------------------------------
// disk_rejection_sampler_core
// Rejection sampler for a thin disk: one candidate request in, at most one
// particle position out.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  s_*      in   tvalid/tready      candidate fractions and draw
//  m_*      out  tvalid/tready      position, index; tlast = final particle
//  cfg_*    in   cfg_we             register index and data, no read-back
//
//  One candidate at a time. The test's length grows with k (k = 0..49, the
//  integer part of the exp argument); the exp series is 12 terms.
//  An accepted candidate then goes through the CORDIC; the angle divider
//  runs alongside the test. Reset is synchronous and restores the register
//  defaults and the count. A new request is taken while a finished result
//  waits in the output reg.
// ----------------------------------------------------------------------------
module disk_rejection_sampler_core #(
  parameter int FRAC_BITS    = dsr_pkg::FRAC_BITS_DEFAULT,
  parameter int CORDIC_STEPS = dsr_pkg::CORDIC_STEPS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [95:0]  s_tdata,   // point_radius_frac, point_height_frac, uniform_draw
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // pos_x, pos_y, pos_z, particle_index
  output logic         m_tlast,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  dsr_pkg::dp_cmd_t    cmd;
  dsr_pkg::dp_status_t st;

  dsr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  dsr_dp #(
    .FRAC_BITS    (FRAC_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_tdata),
    .cmd       (cmd),
    .st        (st),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule
